// ----- rtl/core/pid_controller_with_limits_macros.svh -----
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_WITH_LIMITS_MACROS_SVH
`define PID_CONTROLLER_WITH_LIMITS_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PIDL_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// next-cycle implication
`define PIDL_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define PIDL_ASSERT_IMPL(label, clk, rst_n, a, b)
`define PIDL_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/core/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// PID controller package
// Types, register map and constants shared by the controller modules.
// ----------------------------------------------------------------------------
package pidl_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 5;
	localparam int DIV_W  = 64;

	localparam logic [15:0] DEADBAND_Q16    = 16'd655;
	localparam logic [8:0]  BANG_FRACTION_Q8 = 9'd230;
	localparam logic [8:0]  SOFT_FRACTION_Q8 = 9'd26;
	localparam logic [15:0] STEP_PERIOD_RST = 16'd65;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_GAIN_P           = 3'd0;
	localparam logic [2:0] REG_GAIN_I           = 3'd1;
	localparam logic [2:0] REG_GAIN_D           = 3'd2;
	localparam logic [2:0] REG_STEP_PERIOD      = 3'd3;
	localparam logic [2:0] REG_INTEGRAL_LIMIT   = 3'd4;
	localparam logic [2:0] REG_DERIVATIVE_LIMIT = 3'd5;
	localparam logic [2:0] REG_OUTPUT_LIMIT     = 3'd6;

	typedef struct packed {
		logic signed [31:0] gain_p;
		logic signed [31:0] gain_i;
		logic signed [31:0] gain_d;
		logic [15:0]        step_period;
		logic [15:0]        integral_limit;
		logic [15:0]        derivative_limit;
		logic [15:0]        drive_limit;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/pidl_regs.sv -----
// ----------------------------------------------------------------------------
// PID controller register file
// APB-style configuration registers with read back.
// ----------------------------------------------------------------------------
module pidl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pidl_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output pidl_pkg::cfg_t                cfg
);

	logic [2:0] idx;
	logic       wr;

	assign idx = paddr[4:2];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// gains zero, step period at its reset value, limits zero
			cfg <= {96'd0, pidl_pkg::STEP_PERIOD_RST, 48'd0};
		end else if (wr) begin
			case (idx)
				pidl_pkg::REG_GAIN_P:           cfg.gain_p <= pwdata;
				pidl_pkg::REG_GAIN_I:           cfg.gain_i <= pwdata;
				pidl_pkg::REG_GAIN_D:           cfg.gain_d <= pwdata;
				pidl_pkg::REG_STEP_PERIOD:      cfg.step_period <= pwdata[15:0];
				pidl_pkg::REG_INTEGRAL_LIMIT:   cfg.integral_limit <= pwdata[15:0];
				pidl_pkg::REG_DERIVATIVE_LIMIT: cfg.derivative_limit <= pwdata[15:0];
				pidl_pkg::REG_OUTPUT_LIMIT:     cfg.drive_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pidl_pkg::REG_GAIN_P:           prdata = cfg.gain_p;
			pidl_pkg::REG_GAIN_I:           prdata = cfg.gain_i;
			pidl_pkg::REG_GAIN_D:           prdata = cfg.gain_d;
			pidl_pkg::REG_STEP_PERIOD:      prdata = {16'd0, cfg.step_period};
			pidl_pkg::REG_INTEGRAL_LIMIT:   prdata = {16'd0, cfg.integral_limit};
			pidl_pkg::REG_DERIVATIVE_LIMIT: prdata = {16'd0, cfg.derivative_limit};
			pidl_pkg::REG_OUTPUT_LIMIT:     prdata = {16'd0, cfg.drive_limit};
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

// ----- rtl/core/pidl_mul.sv -----
// ----------------------------------------------------------------------------
// PID controller shared multiplier
// Signed 33x33 multiply with registered product.
// ----------------------------------------------------------------------------
module pidl_mul (
	input  logic                clk,
	input  logic                en,
	input  logic signed [32:0]  a,
	input  logic signed [32:0]  b,
	output logic signed [65:0]  prod_q
);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ----- rtl/core/pidl_div.sv -----
// ----------------------------------------------------------------------------
// PID controller serial divider
// Restoring unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pidl_pkg::DIV_W-1:0]    dividend,
	input  logic [15:0]                   divisor,
	output logic [pidl_pkg::DIV_W-1:0]    quotient,
	output pidl_pkg::div_stat_t           stat
);

	logic [pidl_pkg::DIV_W-1:0]         quo_q;
	logic [15:0]                        rem_q;
	logic [$clog2(pidl_pkg::DIV_W)-1:0] cnt_q;
	logic                               busy_q;
	logic                               done_q;
	logic [16:0]                        trial;
	logic [17:0]                        dif;
	logic                               ge;

	assign trial = {rem_q, quo_q[pidl_pkg::DIV_W-1]};
	assign dif   = {1'b0, trial} - {2'b00, divisor};
	assign ge    = !dif[17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (&cnt_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[pidl_pkg::DIV_W-2:0], ge};
			rem_q <= ge ? dif[15:0] : trial[15:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/core/pid_controller_with_limits.sv -----
// ----------------------------------------------------------------------------
// PID controller with limits
// Positional PID step in signed Q16.16 with deadband, integral separation,
// clamped derivative and a bang-bang / smoothing output stage.
// ----------------------------------------------------------------------------
// One beat in (setpoint, measurement) gives one beat out (drive). A step runs
// the sequencer around one shared 33x33 multiplier (P term, integral increment,
// I term, D numerator), then waits on the bit-serial divider that divides the
// D numerator by the step period (64 quotient bits, then done). A new input
// beat is taken only once the step is back in idle: in_ready is high only while
// the sequencer is idle; a finished drive beat waits in the output register and
// does not block the next input beat, but the following step holds in its last
// state until it is taken. Registers sit on an APB-style port at byte address
// 4*index; pready is always high. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`include "pid_controller_with_limits_macros.svh"

module pid_controller_with_limits (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pidl_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input beat
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [31:0]          setpoint,
	input  logic signed [31:0]          measurement,
	// output beat
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [31:0]          drive
);

	typedef enum logic [3:0] {
		S_IDLE, S_TGT, S_ERR, S_MP, S_MS, S_IU, S_MI, S_MD,
		S_DST, S_DWAIT, S_DCL, S_SUM, S_OUT
	} state_t;

	localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

	pidl_pkg::cfg_t      cfg;
	pidl_pkg::div_stat_t div_stat;

	state_t              state_q;
	logic signed [31:0]  sp_q, meas_q, held_q;
	logic signed [31:0]  e0_q, e1_q;          // e0_q also holds the newest error between steps
	logic signed [33:0]  isum_q;
	logic signed [31:0]  hist0_q, hist1_q, hist2_q;
	logic signed [49:0]  acc_q;                // P + I
	logic signed [32:0]  dterm_q;
	logic signed [31:0]  sum_q;
	logic                gate_q, div_neg_q;
	logic                out_valid_q;
	logic signed [31:0]  drive_q;

	// shared unit hookup
	logic                mul_en;
	logic signed [32:0]  mul_a, mul_b;
	logic signed [65:0]  prod_q;
	logic                div_start;
	logic [63:0]         div_mag, quot;

	// step-local combinational values
	logic [15:0]         dt;
	logic signed [32:0]  tgt_diff, err_wide, e_sum, d_wide;
	logic signed [31:0]  err_sat, d_sat;
	logic [31:0]         e0_abs;
	logic signed [34:0]  isum_next, ilim_w;
	logic signed [64:0]  dq;
	logic signed [64:0]  dlim_w;
	logic signed [50:0]  sum_wide;
	logic [31:0]         sum_abs;
	logic [40:0]         mag, olim40, bang_th, soft_th;
	logic signed [31:0]  bang_val, soft_val, res;
	logic signed [33:0]  s4;

	assign pready = 1'b1;

	pidl_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	pidl_mul u_mul (
		.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod_q(prod_q)
	);

	pidl_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_mag),
		.divisor(dt), .quotient(quot), .stat(div_stat)
	);

	// zero step period behaves as one
	assign dt = (cfg.step_period == 16'd0) ? 16'd1 : cfg.step_period;

	// deadband on the target
	assign tgt_diff = {held_q[31], held_q} - {sp_q[31], sp_q};

	// error, saturated
	assign err_wide = {held_q[31], held_q} - {meas_q[31], meas_q};
	assign err_sat  = (err_wide > 33'sd2147483647) ? INT32_MAX :
	                  (err_wide < -33'sd2147483648) ? INT32_MIN : err_wide[31:0];

	assign e_sum  = {e0_q[31], e0_q} + {e1_q[31], e1_q};
	assign e0_abs = e0_q[31] ? (32'd0 - e0_q) : e0_q;

	// error difference for D, saturated
	assign d_wide = {e0_q[31], e0_q} - {e1_q[31], e1_q};
	assign d_sat  = (d_wide > 33'sd2147483647) ? INT32_MAX :
	                (d_wide < -33'sd2147483648) ? INT32_MIN : d_wide[31:0];

	// integral update, clamped to +-(ilim << 16)
	assign ilim_w    = $signed({3'b000, cfg.integral_limit, 16'd0});
	assign isum_next = $signed({isum_q[33], isum_q})
	                 + $signed({{3{prod_q[48]}}, prod_q[48:17]});

	// multiplier operand select
	always_comb begin
		mul_en = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_MP: begin
				mul_en = 1'b1;
				mul_a  = {e0_q[31], e0_q};
				mul_b  = {cfg.gain_p[31], cfg.gain_p};
			end
			S_MS: begin
				mul_en = 1'b1;
				mul_a  = e_sum;
				mul_b  = $signed({17'd0, dt});
			end
			S_MI: begin
				mul_en = 1'b1;
				mul_a  = isum_q[32:0];
				mul_b  = {cfg.gain_i[31], cfg.gain_i};
			end
			S_MD: begin
				mul_en = 1'b1;
				mul_a  = {d_sat[31], d_sat};
				mul_b  = {cfg.gain_d[31], cfg.gain_d};
			end
			default: ;
		endcase
	end

	// divider takes the magnitude of gain_d * diff
	assign div_start = (state_q == S_DST);
	assign div_mag   = prod_q[65] ? (64'd0 - prod_q[63:0]) : prod_q[63:0];

	// signed quotient, clamped to +-(dlim << 16)
	assign dq     = div_neg_q ? (65'sd0 - $signed({1'b0, quot})) : $signed({1'b0, quot});
	assign dlim_w = $signed({33'd0, cfg.derivative_limit, 16'd0});

	assign sum_wide = $signed({acc_q[49], acc_q}) + $signed({{18{dterm_q[32]}}, dterm_q});

	// output stage: bang-bang above the high threshold, averaging below the low one
	assign sum_abs = sum_q[31] ? (32'd0 - sum_q) : sum_q;
	assign mag     = {1'b0, sum_abs, 8'd0};
	assign olim40  = {9'd0, cfg.drive_limit, 16'd0};
	assign bang_th = olim40 * pidl_pkg::BANG_FRACTION_Q8;
	assign soft_th = olim40 * pidl_pkg::SOFT_FRACTION_Q8;

	always_comb begin
		if (sum_q > 32'sd0) begin
			bang_val = cfg.drive_limit[15] ? INT32_MAX : {cfg.drive_limit, 16'd0};
		end else begin
			bang_val = cfg.drive_limit[15] ? INT32_MIN : (32'd0 - {cfg.drive_limit, 16'd0});
		end
	end

	assign s4       = $signed({{2{sum_q[31]}}, sum_q}) + $signed({{2{hist0_q[31]}}, hist0_q})
	                + $signed({{2{hist1_q[31]}}, hist1_q}) + $signed({{2{hist2_q[31]}}, hist2_q});
	assign soft_val = 32'(($signed(s4) + (s4[33] ? 34'sd3 : 34'sd0)) >>> 2);

	always_comb begin
		priority if (mag > bang_th) begin
			res = bang_val;
		end else if (mag < soft_th) begin
			res = soft_val;
		end else begin
			res = sum_q;
		end
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			meas_q      <= '0;
			held_q      <= '0;
			e0_q        <= '0;
			e1_q        <= '0;
			isum_q      <= '0;
			hist0_q     <= '0;
			hist1_q     <= '0;
			hist2_q     <= '0;
			acc_q       <= '0;
			dterm_q     <= '0;
			sum_q       <= '0;
			gate_q      <= 1'b0;
			div_neg_q   <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= '0;
		end else begin
			// in S_OUT the output register is handled by the step itself
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sp_q    <= setpoint;
						meas_q  <= measurement;
						state_q <= S_TGT;
					end
				end
				S_TGT: begin
					if (tgt_diff > 33'sd655 || tgt_diff < -33'sd655) begin
						held_q <= sp_q;
					end
					state_q <= S_ERR;
				end
				S_ERR: begin
					e1_q    <= e0_q;
					e0_q    <= err_sat;
					state_q <= S_MP;
				end
				S_MP: state_q <= S_MS;
				S_MS: begin
					acc_q   <= {{2{prod_q[63]}}, prod_q[63:16]};
					gate_q  <= {1'b0, e0_abs} < {cfg.integral_limit, 17'd0};
					state_q <= S_IU;
				end
				S_IU: begin
					if (gate_q) begin
						if (isum_next > ilim_w) begin
							isum_q <= ilim_w[33:0];
						end else if (isum_next < -ilim_w) begin
							isum_q <= 34'(-ilim_w);
						end else begin
							isum_q <= isum_next[33:0];
						end
					end
					state_q <= S_MI;
				end
				S_MI: state_q <= S_MD;
				S_MD: begin
					if (gate_q) begin
						acc_q <= acc_q + {{2{prod_q[63]}}, prod_q[63:16]};
					end
					state_q <= S_DST;
				end
				S_DST: begin
					div_neg_q <= prod_q[65];
					state_q   <= S_DWAIT;
				end
				S_DWAIT: begin
					if (div_stat.done) begin
						state_q <= S_DCL;
					end
				end
				S_DCL: begin
					if (dq > dlim_w) begin
						dterm_q <= dlim_w[32:0];
					end else if (dq < -dlim_w) begin
						dterm_q <= 33'(-dlim_w);
					end else begin
						dterm_q <= dq[32:0];
					end
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q <= (sum_wide > 51'sd2147483647) ? INT32_MAX :
					         (sum_wide < -51'sd2147483648) ? INT32_MIN : sum_wide[31:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						drive_q     <= res;
						out_valid_q <= 1'b1;
						hist2_q     <= hist1_q;
						hist1_q     <= hist0_q;
						hist0_q     <= res;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	`PIDL_ASSERT_NEXT(a_accept_starts, clk, arst_n, in_valid && in_ready, state_q == S_TGT)
	`PIDL_ASSERT_IMPL(a_div_start_idle, clk, arst_n, div_start, !div_stat.busy)
	`PIDL_ASSERT_IMPL(a_div_done_wait, clk, arst_n, div_stat.done, state_q == S_DWAIT)
	`PIDL_ASSERT_IMPL(a_out_from_final, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_OUT)

endmodule
